// ----- hw/rtl/msla_pkg.sv -----
package msla_pkg;

  // fixed field widths
  localparam int unsigned SlotW    = 3;
  localparam int unsigned AnimW    = 4;
  localparam int unsigned ColW     = 8;
  localparam int unsigned RefreshW = 16;
  localparam int unsigned FcW      = 8;
  localparam int unsigned DirW     = 4;
  localparam int unsigned PeriodW  = 6;

  localparam int unsigned NumSlots = 8;

  // refresh register
  localparam int unsigned RefreshMinInt = 5;
  localparam logic [RefreshW-1:0] RefreshMin = RefreshW'(RefreshMinInt);
  localparam logic [RefreshW-1:0] RefreshRst = RefreshW'(RefreshMinInt);

  // animation cycle classes, one period register each
  localparam int unsigned NumClasses = 3;
  localparam int unsigned ClassW     = 2;
  localparam logic [ClassW-1:0] ClsSlow = 2'd0;
  localparam logic [ClassW-1:0] ClsMid  = 2'd1;
  localparam logic [ClassW-1:0] ClsFast = 2'd2;

  localparam int unsigned CycleSlowMs = 240;
  localparam int unsigned CycleMidMs  = 48;
  localparam int unsigned CycleFastMs = 6;

  localparam int unsigned PeriodSlowRst =
      (CycleSlowMs / RefreshMinInt) > 0 ? (CycleSlowMs / RefreshMinInt) : 1;
  localparam int unsigned PeriodMidRst =
      (CycleMidMs / RefreshMinInt) > 0 ? (CycleMidMs / RefreshMinInt) : 1;
  localparam int unsigned PeriodFastRst =
      (CycleFastMs / RefreshMinInt) > 0 ? (CycleFastMs / RefreshMinInt) : 1;

  // divider: two quotient bits per cycle over an 8-bit dividend
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivCycles       = FcW / DivBitsPerCycle;
  localparam int unsigned DivCntW         = $clog2(DivCycles);

  // step directions, 4-bit two's complement
  localparam int FadeStepInt = 5;
  localparam logic [DirW-1:0] DirUp5 = DirW'(FadeStepInt);
  localparam logic [DirW-1:0] DirDn5 = DirW'(-FadeStepInt);
  localparam logic [DirW-1:0] DirUp1 = DirW'(1);
  localparam logic [DirW-1:0] DirDn1 = DirW'(-1);

  localparam logic [ColW-1:0] SatFull = 8'd255;

  typedef enum logic [2:0] {
    ModeAlt,
    ModeFade,
    ModePulse,
    ModeCycle,
    ModeDecay
  } mode_e;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    mode_e             mode;
    logic [ColW-1:0]   a;
    logic [ColW-1:0]   b;
    logic [ColW-1:0]   fixed_hue;
    logic [ColW-1:0]   sat;
    logic              halve;
  } anim_row_t;

  typedef struct packed {
    logic [FcW-1:0]  fc;
    logic [ColW-1:0] hue;
    logic [ColW-1:0] level;
    logic [DirW-1:0] dir;
  } slot_state_t;

  localparam slot_state_t SlotStateRst = '{fc: '0, hue: '0, level: '0, dir: DirDn1};

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [AnimW-1:0] anim_index;
    logic [ColW-1:0]  brightness;
  } in_item_t;

  typedef struct packed {
    logic [ColW-1:0] hue;
    logic [ColW-1:0] saturation;
    logic [ColW-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [FcW-1:0]      dividend;
    logic [RefreshW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [FcW-1:0] quot;
    logic [FcW-1:0] rem;
  } div_rsp_t;

  function automatic anim_row_t anim_row(logic [AnimW-1:0] idx);
    anim_row_t r;
    case (idx)
      4'd0: r = '{ClsSlow, ModeAlt,   8'd0,   8'd96,  8'd0,  8'd255, 1'b1};
      4'd1: r = '{ClsSlow, ModeAlt,   8'd15,  8'd210, 8'd0,  8'd255, 1'b0};
      4'd2: r = '{ClsSlow, ModeAlt,   8'd145, 8'd96,  8'd0,  8'd255, 1'b0};
      4'd3: r = '{ClsSlow, ModeAlt,   8'd0,   8'd210, 8'd0,  8'd255, 1'b0};
      4'd4: r = '{ClsMid,  ModePulse, 8'd24,  8'd32,  8'd0,  8'd255, 1'b0};
      4'd5: r = '{ClsFast, ModeDecay, 8'd160, 8'd146, 8'd0,  8'd255, 1'b0};
      4'd6: r = '{ClsMid,  ModeFade,  8'd50,  8'd255, 8'd28, 8'd255, 1'b0};
      4'd7: r = '{ClsMid,  ModeFade,  8'd50,  8'd255, 8'd0,  8'd255, 1'b0};
      4'd8: r = '{ClsMid,  ModeCycle, 8'd0,   8'd5,   8'd0,  8'd128, 1'b0};
      default: r = '{ClsMid, ModeCycle, 8'd0, 8'd5, 8'd0, 8'd255, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [FcW-1:0] cycle_ms(logic [ClassW-1:0] cls);
    logic [FcW-1:0] c;
    case (cls)
      ClsSlow: c = FcW'(CycleSlowMs);
      ClsMid:  c = FcW'(CycleMidMs);
      default: c = FcW'(CycleFastMs);
    endcase
    return c;
  endfunction

  function automatic logic [PeriodW-1:0] period_rst(logic [ClassW-1:0] cls);
    logic [PeriodW-1:0] p;
    case (cls)
      ClsSlow: p = PeriodW'(PeriodSlowRst);
      ClsMid:  p = PeriodW'(PeriodMidRst);
      default: p = PeriodW'(PeriodFastRst);
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/msla_div.sv -----
module msla_div import msla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [FcW-1:0]      quo_q, quo_d;
  logic [FcW-1:0]      rem_q, rem_d;
  logic [RefreshW-1:0] dvs_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;

  // restoring division, two bits per cycle
  always_comb begin
    logic [FcW:0] r9;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DivBitsPerCycle; k++) begin
      r9    = {rem_d, quo_d[FcW-1]};
      quo_d = {quo_d[FcW-2:0], 1'b0};
      if (RefreshW'(r9) >= dvs_q) begin
        rem_d    = FcW'(RefreshW'(r9) - dvs_q);
        quo_d[0] = 1'b1;
      end else begin
        rem_d = r9[FcW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivCycles - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- hw/rtl/msla_state_ram.sv -----
module msla_state_ram import msla_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SlotW-1:0] rd_addr_i,
  output slot_state_t      rd_data_o,
  input  logic             wr_en_i,
  input  logic [SlotW-1:0] wr_addr_i,
  input  slot_state_t      wr_data_i
);

  slot_state_t             mem_q [NumSlots];
  logic [NumSlots-1:0]     valid_q;
  slot_state_t             rd_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read back as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : SlotStateRst;

endmodule

// ----- hw/rtl/msla_step.sv -----
module msla_step import msla_pkg::*; (
  input  anim_row_t       row_i,
  input  slot_state_t     state_i,
  input  logic [ColW-1:0] bright_i,
  input  logic            in_range_i,
  input  logic            adv_i,
  output slot_state_t     state_o,
  output out_item_t       item_o
);

  always_comb begin
    slot_state_t st;
    out_item_t   it;
    logic [9:0]  nb;

    st = state_i;
    nb = '0;

    // entry checks ahead of the period test
    case (row_i.mode)
      ModeAlt: begin
        if (st.hue != row_i.a && st.hue != row_i.b) st.hue = row_i.a;
      end
      ModeFade: begin
        if (st.level == '0) begin
          st.level = row_i.a;
          st.dir   = (row_i.b > row_i.a) ? DirUp5 : DirDn5;
        end
      end
      ModePulse: begin
        if (st.hue < row_i.a || st.hue > row_i.b) begin
          st.hue = row_i.a;
          st.dir = DirUp1;
        end
      end
      ModeDecay: begin
        if (st.hue < row_i.b || st.hue > row_i.a) st.hue = row_i.a;
      end
      default: ;
    endcase

    if (adv_i) begin
      st.fc = FcW'(1);
      case (row_i.mode)
        ModeAlt: begin
          st.hue = (st.hue == row_i.a) ? row_i.b : row_i.a;
        end
        ModeFade: begin
          nb = {2'b00, st.level} + {{(10 - DirW){st.dir[DirW-1]}}, st.dir};
          if ($signed(nb) > $signed({2'b00, row_i.b})) begin
            nb     = {2'b00, row_i.b};
            st.dir = DirDn5;
          end
          if ($signed(nb) < $signed({2'b00, row_i.a})) begin
            nb     = {2'b00, row_i.a};
            st.dir = DirUp5;
          end
          st.level = nb[ColW-1:0];
        end
        ModePulse: begin
          st.hue = st.hue + {{(ColW - DirW){st.dir[DirW-1]}}, st.dir};
          if (st.hue >= row_i.b) st.dir = DirDn1;
          else if (st.hue <= row_i.a) st.dir = DirUp1;
        end
        ModeCycle: begin
          st.hue = st.hue + row_i.b;
        end
        default: begin
          st.hue = st.hue - 8'd1;
          if (st.hue < row_i.b) st.hue = row_i.a;
        end
      endcase
    end else begin
      st.fc = st.fc + 8'd1;
    end

    it.hue        = st.hue;
    it.saturation = SatFull;
    it.value      = bright_i;
    case (row_i.mode)
      ModeAlt: begin
        if (row_i.halve && st.hue == row_i.b) it.value = {1'b0, bright_i[ColW-1:1]};
      end
      ModeFade: begin
        it.hue   = row_i.fixed_hue;
        it.value = st.level;
      end
      ModeCycle: begin
        it.saturation = row_i.sat;
      end
      default: ;
    endcase

    if (!in_range_i) it = '0;

    state_o = st;
    item_o  = it;
  end

endmodule

// ----- hw/rtl/multi_slot_led_color_animator_core.sv -----
// multi-slot led colour animator
//
// input channel (in_valid_i / in_ready_o / in_item_i): one item is one frame
// tick for one slot, naming a built-in animation and a brightness.
// output channel (out_valid_o / out_ready_i / out_item_o): one hue,
// saturation, value item for every input item, in order.
// cfg_we_i / cfg_wdata_i write the refresh period in ms (values below 5
// are taken as 5); the three frame periods are then re-derived by the shared
// divider, one class after another, during which no item is taken.
// an accepted item passes the state memory read, the start and run of the
// frame-count modulo in the divider, and the update, which writes the slot
// state back and loads the output register before the next item is taken.
// reset clears all slot state to its reset value (valid bits, no sweep) and
// loads the periods for a 5 ms refresh; the block is ready straight away.
// a stalled receiver holds the result in the output register; the next item
// is still accepted and worked on, and waits only for the final write-back.
module multi_slot_led_color_animator_core import msla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [RefreshW-1:0] cfg_wdata_i
);

  // item sequencer codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StUpd  = 2'd3;

  // period sequencer codes
  localparam logic [1:0] PsIdle  = 2'd0;
  localparam logic [1:0] PsStart = 2'd1;
  localparam logic [1:0] PsWait  = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [1:0]          ps_q;
  logic [ClassW-1:0]   cls_q;
  logic [RefreshW-1:0] refresh_q;
  logic [PeriodW-1:0]  period_q [NumClasses];
  in_item_t            item_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic        accept;
  logic        out_free;
  logic        in_range;
  anim_row_t   row;
  slot_state_t rd_state;
  slot_state_t new_state;
  out_item_t   new_item;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [PeriodW-1:0] new_period;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign row      = anim_row(item_q.anim_index);
  assign in_range = 32'(item_q.slot) < NumSlots;

  // one item in flight; a config write or period update holds off input
  assign in_ready_o = (st_q == StIdle) && (ps_q == PsIdle) && !cfg_we_i;

  // the shared divider serves the period update and the frame-count modulo
  always_comb begin
    div_req.start = (st_q == StLook) || (ps_q == PsStart);
    if (ps_q == PsStart) begin
      div_req.dividend = cycle_ms(cls_q);
      div_req.divisor  = refresh_q;
    end else begin
      div_req.dividend = rd_state.fc;
      div_req.divisor  = RefreshW'(period_q[row.cls]);
    end
  end

  msla_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // read at acceptance, written back in the update cycle; with one item in
  // flight a read never overlaps a pending write of the same entry
  msla_state_ram u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && (32'(in_item_i.slot) < NumSlots)),
    .rd_addr_i (in_item_i.slot),
    .rd_data_o (rd_state),
    .wr_en_i   ((st_q == StUpd) && out_free && in_range),
    .wr_addr_i (item_q.slot),
    .wr_data_i (new_state)
  );

  msla_step u_step (
    .row_i      (row),
    .state_i    (rd_state),
    .bright_i   (item_q.brightness),
    .in_range_i (in_range),
    .adv_i      (div_rsp.rem == '0),
    .state_o    (new_state),
    .item_o     (new_item)
  );

  // item sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (accept) st_d = StLook;
      StLook: st_d = StDiv;
      StDiv:  if (div_rsp.done) st_d = StUpd;
      StUpd:  if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // refresh register and frame-period update
  assign new_period = (div_rsp.quot == '0) ? PeriodW'(1) : div_rsp.quot[PeriodW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= RefreshRst;
      ps_q      <= PsIdle;
      cls_q     <= ClsSlow;
      for (int i = 0; i < NumClasses; i++) begin
        period_q[i] <= period_rst(ClassW'(i));
      end
    end else if (cfg_we_i) begin
      // a new write restarts the update from the first class
      refresh_q <= (cfg_wdata_i < RefreshMin) ? RefreshMin : cfg_wdata_i;
      ps_q      <= PsStart;
      cls_q     <= ClsSlow;
    end else begin
      case (ps_q)
        PsStart: ps_q <= PsWait;
        PsWait: begin
          if (div_rsp.done) begin
            period_q[cls_q] <= new_period;
            if (cls_q == ClassW'(NumClasses - 1)) begin
              ps_q <= PsIdle;
            end else begin
              cls_q <= cls_q + 1'b1;
              ps_q  <= PsStart;
            end
          end
        end
        default: ps_q <= PsIdle;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((st_q == StUpd) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == StUpd) && out_free) begin
      out_item_q <= new_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/msla_checker.sv -----
module msla_checker import msla_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i,
  input logic      cfg_we_i
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  // a refresh write blocks input while periods are re-derived
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_ready_i ##1 !in_ready_i)
    else $error("item taken during period update");

  // saturation is full, half or the out-of-range zero
  a_sat_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.saturation == 8'd255 ||
                    out_item_i.saturation == 8'd128 ||
                    out_item_i.saturation == 8'd0)
    else $error("unexpected saturation");

endmodule

bind multi_slot_led_color_animator_core msla_checker u_msla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o),
  .cfg_we_i    (cfg_we_i)
);
